// ===== src/ima_pkg.sv =====
// ima_pkg: shared types and constants of the imu moving-average block
// no dependencies; compile first
package ima_pkg;

  localparam int CHANNELS = 6;
  localparam int CH_W     = 16;
  localparam int STAMP_W  = 32;

  typedef logic signed [CH_W-1:0] ima_chan_t;
  typedef logic [STAMP_W-1:0]     ima_stamp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_HOLD
  } ima_state_t;

  // control from the sequencer to every lane
  typedef struct packed {
    logic update;     // fold the new sample into the running sum
    logic full;       // window was full before this sample: drop the oldest
    logic div_start;  // load the divider from the running sum
    logic div_step;   // one quotient bit
  } ima_lane_ctrl_t;

endpackage

// ===== src/ima_if.sv =====
// ima_in_if / ima_out_if: valid-ready channels for samples and window means
// depends on ima_pkg
interface ima_in_if;
  logic                valid;
  logic                ready;
  ima_pkg::ima_chan_t  accel_x_in;
  ima_pkg::ima_chan_t  accel_y_in;
  ima_pkg::ima_chan_t  accel_z_in;
  ima_pkg::ima_chan_t  gyro_x_in;
  ima_pkg::ima_chan_t  gyro_y_in;
  ima_pkg::ima_chan_t  gyro_z_in;
  ima_pkg::ima_stamp_t stamp_in;

  modport source (output valid, accel_x_in, accel_y_in, accel_z_in,
                  gyro_x_in, gyro_y_in, gyro_z_in, stamp_in, input ready);
  modport sink   (input valid, accel_x_in, accel_y_in, accel_z_in,
                  gyro_x_in, gyro_y_in, gyro_z_in, stamp_in, output ready);
endinterface

interface ima_out_if;
  logic                valid;
  logic                ready;
  ima_pkg::ima_chan_t  accel_x_mean;
  ima_pkg::ima_chan_t  accel_y_mean;
  ima_pkg::ima_chan_t  accel_z_mean;
  ima_pkg::ima_chan_t  gyro_x_mean;
  ima_pkg::ima_chan_t  gyro_y_mean;
  ima_pkg::ima_chan_t  gyro_z_mean;
  ima_pkg::ima_stamp_t stamp_out;

  modport source (output valid, accel_x_mean, accel_y_mean, accel_z_mean,
                  gyro_x_mean, gyro_y_mean, gyro_z_mean, stamp_out, input ready);
  modport sink   (input valid, accel_x_mean, accel_y_mean, accel_z_mean,
                  gyro_x_mean, gyro_y_mean, gyro_z_mean, stamp_out, output ready);
endinterface

// ===== src/imu_moving_average.sv =====
// imu_moving_average: top level, sequencer, sample window ram, six lanes and result register
// depends on ima_pkg, ima_if, ima_ram, ima_lane
//
// Moving average over a six-axis imu stream. Each sample transaction
// (three accelerometer and three gyro channels, signed 16 bit, plus a
// 32-bit timestamp) is written into a circular window of WINDOW entries,
// and exactly one result transaction follows: per channel, the mean over
// the filled entries, truncated toward zero, with the timestamp of that
// same sample. Until WINDOW samples have arrived the mean is taken over
// the samples seen so far. After acceptance a sample passes the read,
// update, load, divide and hold states before its result is loaded into
// the output register; the bit-serial divider in each lane produces one
// quotient bit per cycle. Samples are processed one at a time; a new
// sample is accepted as soon as the previous result sits in the output
// register, even if the sink has not yet taken it. A result still waiting
// for the sink holds the next one in the last step until the output
// register frees up. No clearing pass is needed after reset.
module imu_moving_average #(
  parameter int WINDOW = 16
) (
  input  logic     clk,
  input  logic     rst,
  ima_in_if.sink   samples,
  ima_out_if.source means
);
  import ima_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = 17 + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int ROW_W  = CHANNELS * CH_W;

  ima_state_t state, state_next;

  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  cnt;

  // captured sample
  ima_chan_t  smp [CHANNELS];
  ima_stamp_t stamp_q;

  // window ram
  logic [ROW_W-1:0] row_wdata;
  logic [ROW_W-1:0] row_rdata;
  logic             ram_we;

  // lane control and results
  ima_lane_ctrl_t ctrl;
  ima_chan_t      lane_mean [CHANNELS];

  // output register
  logic       out_valid;
  ima_chan_t  out_mean [CHANNELS];
  ima_stamp_t out_stamp;

  logic smp_take;
  logic out_load;
  logic full;

  assign smp_take = samples.valid && samples.ready;
  assign full     = (fill == FILL_W'(WINDOW));

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (samples.valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (cnt == '0) state_next = ST_HOLD;
      ST_HOLD:   if (!out_valid || means.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // state outputs
  // ---------------------------------------------------------------------
  always_comb begin
    samples.ready  = 1'b0;
    ram_we         = 1'b0;
    out_load       = 1'b0;
    ctrl           = '0;
    ctrl.full      = full;
    unique case (state)
      ST_IDLE:   samples.ready  = 1'b1;
      ST_READ:   ;
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        ram_we      = 1'b1;
      end
      ST_LOAD:   ctrl.div_start = 1'b1;
      ST_DIVIDE: ctrl.div_step  = 1'b1;
      ST_HOLD:   out_load = !out_valid || means.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // write slot, fill count and divide step counter
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
      cnt  <= '0;
    end else begin
      if (state == ST_UPDATE) begin
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
      if (state == ST_LOAD) begin
        cnt <= CNT_W'(SUM_W - 1);
      end else if (state == ST_DIVIDE && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (smp_take) begin
      smp[0]  <= samples.accel_x_in;
      smp[1]  <= samples.accel_y_in;
      smp[2]  <= samples.accel_z_in;
      smp[3]  <= samples.gyro_x_in;
      smp[4]  <= samples.gyro_y_in;
      smp[5]  <= samples.gyro_z_in;
      stamp_q <= samples.stamp_in;
    end
  end

  // ---------------------------------------------------------------------
  // window store: the old row at the write slot is read in the cycle before
  // the write, so a full window can drop it from the running sums
  // ---------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      row_wdata[c*CH_W +: CH_W] = smp[c];
    end
  end

  ima_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (row_wdata),
    .raddr (slot),
    .rdata (row_rdata)
  );

  // ---------------------------------------------------------------------
  // one lane per channel
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    ima_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .new_val (smp[g]),
      .old_val (ima_chan_t'(row_rdata[g*CH_W +: CH_W])),
      .divisor (fill),
      .mean    (lane_mean[g])
    );
  end

  // ---------------------------------------------------------------------
  // merge lane results into the output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (means.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_mean[c] <= lane_mean[c];
      end
      out_stamp <= stamp_q;
    end
  end

  assign means.valid        = out_valid;
  assign means.accel_x_mean = out_mean[0];
  assign means.accel_y_mean = out_mean[1];
  assign means.accel_z_mean = out_mean[2];
  assign means.gyro_x_mean  = out_mean[3];
  assign means.gyro_y_mean  = out_mean[4];
  assign means.gyro_z_mean  = out_mean[5];
  assign means.stamp_out    = out_stamp;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // until the window is full the write slot equals the fill count
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FILL_W'(WINDOW)) |-> (slot == SLOT_W'(fill)))
    else $error("write slot out of step with fill count");

  // each transaction grows the fill count by one until saturation
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && fill != FILL_W'(WINDOW)) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count did not advance");

  // a pending result is never overwritten by the next one
  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && out_valid && !means.ready) |=> (state == ST_HOLD))
    else $error("result register overwritten while occupied");

  // the divider always runs its full length before a result is loaded
  a_divide_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_DIVIDE && cnt == CNT_W'(SUM_W - 1)))
    else $error("divider started with wrong step count");

endmodule

// ===== src/ima_ram.sv =====
// ima_ram: generic single-write, single-read ram with registered read data
// no dependencies
module ima_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ima_lane.sv =====
// ima_lane: running window sum and bit-serial signed divider for one channel
// depends on ima_pkg
module ima_lane #(
  parameter int WINDOW = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ima_pkg::ima_lane_ctrl_t        ctrl,
  input  ima_pkg::ima_chan_t             new_val,
  input  ima_pkg::ima_chan_t             old_val,
  input  logic [$clog2(WINDOW+1)-1:0]    divisor,
  output ima_pkg::ima_chan_t             mean
);
  import ima_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = 17 + $clog2(WINDOW);
  localparam int REM_W  = FILL_W + 1;

  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] quo;
  logic        [REM_W-1:0] rem;
  logic                    neg;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W:0]   diff;

  assign rem_sh = {rem[REM_W-2:0], quo[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, divisor};

  // running sum: add newest, drop the overwritten entry once full
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.update) begin
      sum <= sum + SUM_W'(new_val) - (ctrl.full ? SUM_W'(old_val) : SUM_W'(0));
    end
  end

  // restoring division of |sum|, one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      neg <= sum[SUM_W-1];
      quo <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem <= '0;
    end else if (ctrl.div_step) begin
      if (!diff[REM_W]) begin
        rem <= diff[REM_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  // truncation toward zero: divide magnitude, then restore sign
  assign mean = neg ? ima_chan_t'(-quo[CH_W-1:0]) : ima_chan_t'(quo[CH_W-1:0]);

endmodule

// ===== bench/imu_moving_average_tb.sv =====
`timescale 1ns / 100ps
// imu_moving_average_tb: self-checking bench for the six-axis moving-average block
// depends on ima_pkg, ima_in_if / ima_out_if and imu_moving_average
// sample transactions in, window-mean transactions checked against an in-bench window model
module imu_moving_average_tb;
  import ima_pkg::*;

  localparam int WINDOW      = 16;
  localparam int N_RANDOM    = 2000;
  localparam int LIMIT       = 600000;   // cycles; watchdog limit for the whole run
  localparam int SETTLE      = 60;       // settling wait after the last expected mean
  localparam int TAIL_ITEMS  = 200;      // last stretch runs with no random idling
  localparam int MAX_REPORTS = 40;

  // one sample or one mean: chan[0..2] accel x/y/z, chan[3..5] gyro x/y/z
  typedef struct packed {
    ima_chan_t [CHANNELS-1:0] chan;
    ima_stamp_t               stamp;
  } imu_frame_t;

  logic clk = 1'b0;
  logic rst;

  ima_in_if  samples_if ();
  ima_out_if means_if ();

  imu_moving_average #(.WINDOW(WINDOW)) u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .means   (means_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectation stores
  imu_frame_t pending_samples [$];
  imu_frame_t expected_means [$];

  int n_queued   = 0;
  int n_directed = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int cycle_count = 0;
  bit stim_done  = 1'b0;

  // idling state of both sides
  int send_gap   = 0;
  int take_stall = 0;
  int send_odds  = 0;   // 0 gives a stretch with no sender gaps
  int take_odds  = 2;   // 0 gives a stretch with no receiver stalls

  string chan_name [CHANNELS] = '{"accel_x", "accel_y", "accel_z",
                                  "gyro_x", "gyro_y", "gyro_z"};

  // ---------------------------------------------------------------------------
  // window model: circular store, next slot and fill level, as the block keeps them
  // ---------------------------------------------------------------------------
  ima_chan_t   window_store [WINDOW][CHANNELS];
  int unsigned next_slot = 0;
  int unsigned filled    = 0;

  // push one accepted sample and return the mean over the filled entries
  function automatic imu_frame_t push_and_average(input imu_frame_t s);
    imu_frame_t m;
    int         sum;
    for (int c = 0; c < CHANNELS; c++)
      window_store[next_slot][c] = s.chan[c];
    next_slot = (next_slot + 1) % WINDOW;
    if (filled < WINDOW) filled++;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = 0;
      // entries 0 .. filled-1 are exactly the written ones, wrapped or not
      for (int i = 0; i < filled; i++)
        sum += int'(window_store[i][c]);
      // int division truncates toward zero, matching the block
      m.chan[c] = ima_chan_t'(sum / int'(filled));
    end
    m.stamp = s.stamp;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (n_errors < MAX_REPORTS)
      $display("%0t: mean %0d: %s got %0d expected %0d", $time, n_checked, what, got, want);
    n_errors++;
  endtask

  function automatic bit in_tail();
    return stim_done && (n_queued - n_accepted < TAIL_ITEMS);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued samples, holds each until the block takes it
  // ---------------------------------------------------------------------------
  imu_frame_t sent_sample, next_sample;

  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        sent_sample.chan[0] = samples_if.accel_x_in;
        sent_sample.chan[1] = samples_if.accel_y_in;
        sent_sample.chan[2] = samples_if.accel_z_in;
        sent_sample.chan[3] = samples_if.gyro_x_in;
        sent_sample.chan[4] = samples_if.gyro_y_in;
        sent_sample.chan[5] = samples_if.gyro_z_in;
        sent_sample.stamp   = samples_if.stamp_in;
        expected_means.push_back(push_and_average(sent_sample));
        n_accepted++;
        // fresh idling mix every 128 transactions, sometimes none
        if (n_accepted % 128 == 0) send_odds = $urandom_range(0, 5);
      end

      if (samples_if.valid && !samples_if.ready) begin
        // transaction still offered, payload stays put
      end else if (send_gap != 0) begin
        send_gap--;
        samples_if.valid <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        samples_if.valid <= 1'b0;
      end else if (!in_tail() && send_odds != 0 && $urandom_range(0, 15) < send_odds) begin
        // a random burst of idle cycles, this one included
        send_gap = $urandom_range(1, 14) - 1;
        samples_if.valid <= 1'b0;
      end else begin
        next_sample = pending_samples.pop_front();
        samples_if.accel_x_in <= next_sample.chan[0];
        samples_if.accel_y_in <= next_sample.chan[1];
        samples_if.accel_z_in <= next_sample.chan[2];
        samples_if.gyro_x_in  <= next_sample.chan[3];
        samples_if.gyro_y_in  <= next_sample.chan[4];
        samples_if.gyro_z_in  <= next_sample.chan[5];
        samples_if.stamp_in   <= next_sample.stamp;
        samples_if.valid      <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes mean transactions with random back-pressure and checks them
  // ---------------------------------------------------------------------------
  imu_frame_t got_mean, want_mean;

  always @(posedge clk) begin
    if (rst) begin
      means_if.ready <= 1'b0;
    end else begin
      if (means_if.valid && means_if.ready) begin
        got_mean.chan[0] = means_if.accel_x_mean;
        got_mean.chan[1] = means_if.accel_y_mean;
        got_mean.chan[2] = means_if.accel_z_mean;
        got_mean.chan[3] = means_if.gyro_x_mean;
        got_mean.chan[4] = means_if.gyro_y_mean;
        got_mean.chan[5] = means_if.gyro_z_mean;
        got_mean.stamp   = means_if.stamp_out;
        if (expected_means.size() == 0) begin
          report_mismatch("transaction with no sample behind it, stamp",
                          longint'(got_mean.stamp), 0);
        end else begin
          want_mean = expected_means.pop_front();
          for (int c = 0; c < CHANNELS; c++)
            if (got_mean.chan[c] !== want_mean.chan[c])
              report_mismatch(chan_name[c], longint'($signed(got_mean.chan[c])),
                              longint'($signed(want_mean.chan[c])));
          if (got_mean.stamp !== want_mean.stamp)
            report_mismatch("stamp", longint'(got_mean.stamp), longint'(want_mean.stamp));
        end
        n_checked++;
        if (n_checked % 128 == 0) take_odds = $urandom_range(0, 5);
      end

      if (take_stall != 0) begin
        take_stall--;
        means_if.ready <= 1'b0;
      end else if (!in_tail() && take_odds != 0 && $urandom_range(0, 15) < take_odds) begin
        take_stall = $urandom_range(1, 14) - 1;
        means_if.ready <= 1'b0;
      end else begin
        means_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  ima_chan_t   drift_base [CHANNELS];
  ima_stamp_t  stamp_clock = '0;

  task automatic queue_sample(input imu_frame_t s);
    pending_samples.push_back(s);
    n_queued++;
  endtask

  // extremes filling the window and wrapping it, truncation of negative means,
  // stamps at zero, all ones and single bits
  task automatic load_directed();
    imu_frame_t s;
    for (int i = 0; i < 18; i++) begin
      s.chan[0] = ima_chan_t'(-32768);
      s.chan[1] = ima_chan_t'(32767);
      s.chan[2] = i[0] ? ima_chan_t'(32767) : ima_chan_t'(-32768);
      s.chan[3] = ima_chan_t'(-1);
      // -2, 1, 1, -2 ...: partial sums give small negative fractions
      s.chan[4] = (i % 3 == 0) ? ima_chan_t'(-2) : ima_chan_t'(1);
      s.chan[5] = 16'h5555 ^ {16{i[0]}};
      s.stamp   = (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : 32'h8000_0000 + i;
      queue_sample(s);
    end
    // swap the extremes so the wrapped window holds a mix
    for (int i = 18; i < 24; i++) begin
      s.chan[0] = ima_chan_t'(32767);
      s.chan[1] = ima_chan_t'(-32768);
      s.chan[2] = '0;
      s.chan[3] = ima_chan_t'(1);
      s.chan[4] = ima_chan_t'(-32768 + i);
      s.chan[5] = ima_chan_t'(32767 - i);
      s.stamp   = 32'h1 << i;
      queue_sample(s);
    end
    n_directed = n_queued;
  endtask

  task automatic load_random(input int count);
    imu_frame_t s;
    int         style;
    int         k;
    for (k = 0; k < count; k++) begin
      style = $urandom_range(0, 9);
      if (style == 0)
        for (int c = 0; c < CHANNELS; c++) drift_base[c] = ima_chan_t'($urandom);
      for (int c = 0; c < CHANNELS; c++) begin
        case (style)
          0, 1, 2, 3: s.chan[c] = ima_chan_t'($urandom);
          4, 5:       s.chan[c] = ima_chan_t'(int'($urandom_range(0, 6)) - 3);
          6: begin
            case ($urandom_range(0, 3))
              0:       s.chan[c] = ima_chan_t'(-32768);
              1:       s.chan[c] = ima_chan_t'(32767);
              2:       s.chan[c] = ima_chan_t'(-1);
              default: s.chan[c] = '0;
            endcase
          end
          // sensor-like: noise around a slowly held level
          default:    s.chan[c] = drift_base[c] + ima_chan_t'(int'($urandom_range(0, 64)) - 32);
        endcase
      end
      stamp_clock += $urandom_range(1, 20);
      s.stamp = ($urandom_range(0, 19) == 0) ? ima_stamp_t'($urandom) : stamp_clock;
      queue_sample(s);
    end
  endtask

  task automatic wait_for_drain();
    while (n_accepted != n_queued || expected_means.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst                   = 1'b1;
    samples_if.valid      = 1'b0;
    samples_if.accel_x_in = '0;
    samples_if.accel_y_in = '0;
    samples_if.accel_z_in = '0;
    samples_if.gyro_x_in  = '0;
    samples_if.gyro_y_in  = '0;
    samples_if.gyro_z_in  = '0;
    samples_if.stamp_in   = '0;
    means_if.ready        = 1'b0;
    for (int c = 0; c < CHANNELS; c++) drift_base[c] = ima_chan_t'($urandom);

    load_directed();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender waits for every outstanding mean before the random part
    wait_for_drain();
    repeat (20) @(posedge clk);
    load_random(N_RANDOM / 2);
    wait_for_drain();
    load_random(N_RANDOM - N_RANDOM / 2);
    stim_done = 1'b1;

    wait_for_drain();
    // catch any stray transaction after the last expected mean
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d samples (%0d directed) through a %0d-entry window, %0d means checked",
             n_accepted, n_directed, WINDOW, n_checked);
    $display("random idling on both sides, %0d mismatches", n_errors);
    if (n_errors == 0 && expected_means.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
